// ===== hdl/uartrx_pkg.sv =====
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types and constants for the serial receive path with marker capture.
// ----------------------------------------------------------------------------
package uartrx_pkg;

   localparam int DEFAULT_FIFO_DEPTH = 128;

   localparam int BYTE_W  = 8;
   localparam int FILL_W  = 7;
   localparam int STEER_W = 15;
   localparam int COEF_W  = 24;
   localparam int PROD_W  = 40;
   localparam int QUO_W   = 13;
   localparam int TAB_N   = 1 << BYTE_W;

   // steering = round(coef * d^2 / 1e8) + base, in 1/16 units
   localparam logic [COEF_W-1:0]  POS_COEF   = 24'd9842368;
   localparam logic [COEF_W-1:0]  NEG_COEF   = 24'd12302400;
   localparam logic [PROD_W-1:0]  STEER_DIV  = 40'd100000000;
   localparam logic [PROD_W-1:0]  STEER_HALF = 40'd50000000;
   localparam logic [STEER_W-1:0] POS_BASE   = 15'd14400;
   localparam logic [STEER_W-1:0] NEG_BASE   = 15'd20800;
   localparam logic [STEER_W-1:0] STEER_MIN  = 15'd14400;
   localparam logic [STEER_W-1:0] STEER_MAX  = 15'd28800;

   localparam logic [BYTE_W-1:0] POS_MARKER_RESET = 8'd254;
   localparam logic [BYTE_W-1:0] NEG_MARKER_RESET = 8'd255;

   typedef enum logic [1:0] {
      CMD_RECV  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_POS_MARKER = 1'b0,
      REG_NEG_MARKER = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic              start;
      logic              negative;
      logic [BYTE_W-1:0] rx_byte;
   } steer_req_type;

   typedef struct packed {
      logic               done;
      logic [STEER_W-1:0] value;
   } steer_rsp_type;

endpackage

// ===== hdl/uart_rx_marker_parser_fifo_top.sv =====
// ----------------------------------------------------------------------------
// uart_rx_marker_parser_fifo_top
// Serial receive path: marker-armed steering capture and a byte ring buffer.
// ----------------------------------------------------------------------------
// One item is worked at a time. A receive that is stored, dropped or taken as
// a marker, a flush, an empty read and the unused command go from accept
// straight to the done state; a read that pops a byte first waits for the
// registered read of the byte store; a captured steering byte first waits
// for the three register stages of the steering unit (byte distance,
// table lookup, base offset). A finished result sits in the output register,
// and the next item is accepted while it waits. The buffer holds at most
// FIFO_DEPTH-1 bytes.
// ----------------------------------------------------------------------------
module uart_rx_marker_parser_fifo_top
   import uartrx_pkg::*;
#(
   parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,  // [7:0] rx_byte
   input  logic [1:0]        req_tuser,  // [1:0] cmd
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,  // [7:0] data_byte, [14:8] fill_count,
                                         // [29:15] steering_value
   output logic [1:0]        rsp_tuser,  // [0] data_valid, [1] angle_valid
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(FIFO_DEPTH);
   localparam int FW    = (IDX_W + 1 > FILL_W) ? IDX_W + 1 : FILL_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MEM  = 4'b0010,
      ST_CALC = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               pos_pend_ff, pos_pend_in;
   logic               neg_pend_ff, neg_pend_in;
   logic [BYTE_W-1:0]  pos_marker_ff, neg_marker_ff;

   logic               res_dv_ff, res_dv_in;
   logic               res_av_ff, res_av_in;
   logic [BYTE_W-1:0]  res_byte_ff, res_byte_in;
   logic [FILL_W-1:0]  res_fill_ff, res_fill_in;
   logic [STEER_W-1:0] res_steer_ff, res_steer_in;

   logic               out_vld_ff, out_vld_in;
   logic               out_dv_ff, out_av_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [FILL_W-1:0]  out_fill_ff;
   logic [STEER_W-1:0] out_steer_ff;

   logic               accept;
   logic               out_free;
   cmd_type            cmd;
   logic [BYTE_W-1:0]  rx_byte;
   logic [IDX_W-1:0]   wr_next, rd_next;
   logic [IDX_W:0]     fill_wide;
   logic [FW-1:0]      fill_ext;
   logic               mem_wr_en, mem_rd_en;
   logic [BYTE_W-1:0]  mem_rd_data;
   steer_req_type      steer_req;
   steer_rsp_type      steer_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign rx_byte    = req_tdata[BYTE_W-1:0];

   assign wr_next = (wr_idx_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0 : wr_idx_ff + IDX_W'(1);
   assign rd_next = (rd_idx_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0 : rd_idx_ff + IDX_W'(1);

   assign fill_wide = (wr_idx_in >= rd_idx_in)
                    ? {1'b0, wr_idx_in} - {1'b0, rd_idx_in}
                    : {1'b0, wr_idx_in} + (IDX_W + 1)'(FIFO_DEPTH) - {1'b0, rd_idx_in};
   assign fill_ext  = FW'(fill_wide);

   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      pos_pend_in  = pos_pend_ff;
      neg_pend_in  = neg_pend_ff;
      res_dv_in    = res_dv_ff;
      res_av_in    = res_av_ff;
      res_byte_in  = res_byte_ff;
      res_fill_in  = res_fill_ff;
      res_steer_in = res_steer_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      steer_req    = '{start: 1'b0, negative: 1'b0, rx_byte: rx_byte};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_dv_in    = 1'b0;
               res_av_in    = 1'b0;
               res_byte_in  = '0;
               res_steer_in = '0;
               state_in     = ST_DONE;
               unique case (cmd)
                  CMD_RECV: begin
                     if (pos_pend_ff) begin
                        pos_pend_in     = 1'b0;
                        steer_req.start = 1'b1;
                        res_av_in       = 1'b1;
                        state_in        = ST_CALC;
                     end else if (neg_pend_ff) begin
                        neg_pend_in        = 1'b0;
                        steer_req.start    = 1'b1;
                        steer_req.negative = 1'b1;
                        res_av_in          = 1'b1;
                        state_in           = ST_CALC;
                     end else if (rx_byte == pos_marker_ff) begin
                        pos_pend_in = 1'b1;
                     end else if (rx_byte == neg_marker_ff) begin
                        neg_pend_in = 1'b1;
                     end else if (wr_next != rd_idx_ff) begin
                        mem_wr_en = 1'b1;
                        wr_idx_in = wr_next;
                     end
                  end
                  CMD_READ: begin
                     if (wr_idx_ff != rd_idx_ff) begin
                        mem_rd_en = 1'b1;
                        rd_idx_in = rd_next;
                        res_dv_in = 1'b1;
                        state_in  = ST_MEM;
                     end
                  end
                  CMD_FLUSH: begin
                     wr_idx_in = rd_idx_ff;
                  end
                  CMD_NOP: begin
                  end
                  default: begin
                  end
               endcase
               res_fill_in = fill_ext[FILL_W-1:0];
            end
         end
         ST_MEM: begin
            res_byte_in = mem_rd_data;
            state_in    = ST_DONE;
         end
         ST_CALC: begin
            if (steer_rsp.done) begin
               res_steer_in = steer_rsp.value;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         pos_pend_ff   <= 1'b0;
         neg_pend_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
         pos_marker_ff <= POS_MARKER_RESET;
         neg_marker_ff <= NEG_MARKER_RESET;
      end else begin
         state_ff    <= state_in;
         wr_idx_ff   <= wr_idx_in;
         rd_idx_ff   <= rd_idx_in;
         pos_pend_ff <= pos_pend_in;
         neg_pend_ff <= neg_pend_in;
         out_vld_ff  <= out_vld_in;
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_POS_MARKER: pos_marker_ff <= csr_wdata;
               REG_NEG_MARKER: neg_marker_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      res_dv_ff    <= res_dv_in;
      res_av_ff    <= res_av_in;
      res_byte_ff  <= res_byte_in;
      res_fill_ff  <= res_fill_in;
      res_steer_ff <= res_steer_in;
      if (state_ff == ST_DONE && out_free) begin
         out_dv_ff    <= res_dv_ff;
         out_av_ff    <= res_av_ff;
         out_byte_ff  <= res_byte_ff;
         out_fill_ff  <= res_fill_ff;
         out_steer_ff <= res_steer_ff;
      end
   end

   uartrx_fifo_mem #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (rx_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   uartrx_steer u_steer (
      .clock (clock),
      .reset (reset),
      .req   (steer_req),
      .rsp   (steer_rsp)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_steer_ff, out_fill_ff, out_byte_ff};
   assign rsp_tuser  = {out_av_ff, out_dv_ff};

`ifndef ASSERT_OFF
   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      !(pos_pend_ff && neg_pend_ff))
      else $error("both captures pending");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff <= IDX_W'(FIFO_DEPTH - 1)) && (rd_idx_ff <= IDX_W'(FIFO_DEPTH - 1)))
      else $error("ring index out of range");

   a_steer_done_calc: assert property (@(posedge clock) disable iff (reset)
      steer_rsp.done |-> (state_ff == ST_CALC))
      else $error("steering result outside capture wait");

   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_av_ff) |-> (out_steer_ff >= STEER_MIN && out_steer_ff <= STEER_MAX))
      else $error("steering value out of range");
`endif

endmodule

// ===== hdl/uartrx_fifo_mem.sv =====
// ----------------------------------------------------------------------------
// uartrx_fifo_mem
// Byte store of the receive ring buffer: one write port, one registered read.
// ----------------------------------------------------------------------------
module uartrx_fifo_mem
   import uartrx_pkg::*;
#(
   parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
   parameter int IDX_W      = $clog2(FIFO_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_ff [FIFO_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/uartrx_steer.sv =====
// ----------------------------------------------------------------------------
// uartrx_steer
// Steering value from a captured byte: constant quotient tables indexed by
// the byte distance, then the base offset. Three register stages.
// ----------------------------------------------------------------------------
module uartrx_steer
   import uartrx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  steer_req_type req,
   output steer_rsp_type rsp
);

   logic               v1_ff, v1_in;
   logic               v2_ff, v2_in;
   logic               done_ff, done_in;
   logic               neg1_ff, neg2_ff;
   logic [BYTE_W-1:0]  d_ff;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [STEER_W-1:0] value_ff, value_in;
   logic [QUO_W-1:0]   pos_tab [TAB_N];
   logic [QUO_W-1:0]   neg_tab [TAB_N];

   for (genvar g = 0; g < TAB_N; g++) begin : g_tab
      assign pos_tab[g] = QUO_W'((64'(POS_COEF) * 64'(g * g) + 64'(STEER_HALF))
                                 / 64'(STEER_DIV));
      assign neg_tab[g] = QUO_W'((64'(NEG_COEF) * 64'(g * g) + 64'(STEER_HALF))
                                 / 64'(STEER_DIV));
   end

   assign v1_in    = req.start;
   assign v2_in    = v1_ff;
   assign done_in  = v2_ff;
   assign quo_in   = neg1_ff ? neg_tab[d_ff] : pos_tab[d_ff];
   assign value_in = STEER_W'(quo_ff) + (neg2_ff ? NEG_BASE : POS_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         d_ff    <= req.negative ? req.rx_byte : ~req.rx_byte;
         neg1_ff <= req.negative;
      end
      quo_ff   <= quo_in;
      neg2_ff  <= neg1_ff;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule
